/* design/arpc_pkg.sv */
`default_nettype none

package arpc_pkg;

    // Cache geometry
    localparam int ENTRIES_DEF = 32;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int LINE_W      = IP_W + MAC_W;

    // APB register map, one 64-bit register every 8 bytes
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;
    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
    localparam logic [1:0] REG_LOCAL_MAC   = 2'd2;

    // Result actions
    localparam logic [2:0] ACT_DROP     = 3'd0;
    localparam logic [2:0] ACT_SEND_MAC = 3'd1;
    localparam logic [2:0] ACT_ARP_REQ  = 3'd2;
    localparam logic [2:0] ACT_BAD_ARP  = 3'd3;
    localparam logic [2:0] ACT_NO_REPLY = 3'd4;
    localparam logic [2:0] ACT_REPLY    = 3'd5;

    // ARP header values
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    typedef struct packed {
        logic [IP_W-1:0]  local_ip;
        logic [IP_W-1:0]  subnet_mask;
        logic [MAC_W-1:0] local_mac;
    } cfg_t;

endpackage

`default_nettype wire

/* design/arpc_ram.sv */
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/arpc_cfg.sv */
`default_nettype none

module arpc_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [arpc_pkg::APB_AW-1:0] paddr,
    input  wire logic [arpc_pkg::APB_DW-1:0] pwdata,
    output logic      [arpc_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output arpc_pkg::cfg_t                   cfg
);

    arpc_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                arpc_pkg::REG_LOCAL_IP:    cfg_reg.local_ip    <= pwdata[arpc_pkg::IP_W-1:0];
                arpc_pkg::REG_SUBNET_MASK: cfg_reg.subnet_mask <= pwdata[arpc_pkg::IP_W-1:0];
                arpc_pkg::REG_LOCAL_MAC:   cfg_reg.local_mac   <= pwdata[arpc_pkg::MAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            arpc_pkg::REG_LOCAL_IP:
                prdata = {{(arpc_pkg::APB_DW-arpc_pkg::IP_W){1'b0}}, cfg_reg.local_ip};
            arpc_pkg::REG_SUBNET_MASK:
                prdata = {{(arpc_pkg::APB_DW-arpc_pkg::IP_W){1'b0}}, cfg_reg.subnet_mask};
            arpc_pkg::REG_LOCAL_MAC:
                prdata = {{(arpc_pkg::APB_DW-arpc_pkg::MAC_W){1'b0}}, cfg_reg.local_mac};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/arpc_rank.sv */
`default_nettype none

// Recency ranks, one per entry, rank 0 most recent. Ranks always form a
// permutation, so the entry of rank ENTRIES-1 is the replacement victim.
module arpc_rank #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [IW-1:0] rd_idx,
    output logic      [IW-1:0] rd_rank,
    input  wire logic          upd_en,
    input  wire logic [IW-1:0] upd_idx,
    input  wire logic [IW-1:0] upd_rank
);

    logic [IW-1:0] rank_reg [ENTRIES];

    assign rd_rank = rank_reg[rd_idx];

    // move-to-front: everything ahead of the old rank slides back one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= IW'(i);
            end
        end else if (upd_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) == upd_idx) begin
                    rank_reg[i] <= '0;
                end else if (rank_reg[i] < upd_rank) begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* design/arp_resolver_lru_cache_unit.sv */
`default_nettype none

// ARP resolver with an LRU-ordered IP-to-MAC cache.
// Flow: a cache lookup goes from the input transfer through the scan, update
//   and output states to the output register; a dropped or malformed packet
//   goes from the input transfer straight to the output state. The scan reads
//   the line RAM linearly, one entry read per cycle, and a new packet is
//   accepted only in the idle state. A full output register holds the item
//   in the output state, and the input waits until the result is loaded.
// Reset (aresetn low, synchronous): config registers to zero, all entries
//   invalid, entry i at rank i; RAM contents are left as they are.
module arp_resolver_lru_cache_unit #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [arpc_pkg::APB_AW-1:0] paddr,
    input  wire logic [arpc_pkg::APB_DW-1:0] pwdata,
    output logic      [arpc_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // dest_ip[31:0], gateway_ip[63:32], hw_space[79:64], hw_len[87:80],
    // proto_space[103:88], proto_len[111:104], arp_opcode[127:112],
    // sender_ip[159:128], sender_mac[207:160], target_ip[239:208],
    // tx_busy[240], zero fill [247:241]
    input  wire logic [247:0]                s_tdata,
    // mode[0]
    input  wire logic [0:0]                  s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // next_hop_ip[31:0], dest_mac[79:32]
    output logic      [79:0]                 m_tdata,
    // action[2:0]
    output logic      [2:0]                  m_tuser
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IP_W  = arpc_pkg::IP_W;
    localparam int MAC_W = arpc_pkg::MAC_W;
    localparam int LINE_W = arpc_pkg::LINE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_OUT} state_t;

    arpc_pkg::cfg_t cfg;

    arpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------
    // Input field unpack
    // ---------------------------------------------------------------
    logic              in_mode;
    logic [IP_W-1:0]   in_dest_ip, in_gateway_ip, in_sender_ip, in_target_ip;
    logic [15:0]       in_hw_space, in_proto_space, in_arp_opcode;
    logic [7:0]        in_hw_len, in_proto_len;
    logic [MAC_W-1:0]  in_sender_mac;
    logic              in_tx_busy;

    assign in_mode        = s_tuser[0];
    assign in_dest_ip     = s_tdata[31:0];
    assign in_gateway_ip  = s_tdata[63:32];
    assign in_hw_space    = s_tdata[79:64];
    assign in_hw_len      = s_tdata[87:80];
    assign in_proto_space = s_tdata[103:88];
    assign in_proto_len   = s_tdata[111:104];
    assign in_arp_opcode  = s_tdata[127:112];
    assign in_sender_ip   = s_tdata[159:128];
    assign in_sender_mac  = s_tdata[207:160];
    assign in_target_ip   = s_tdata[239:208];
    assign in_tx_busy     = s_tdata[240];

    // Routing: local destination first, then the gateway if it is local.
    logic [IP_W-1:0] local_net;
    logic            dst_local, gw_local, route_ok, fmt_ok;
    logic [IP_W-1:0] route_ip;

    assign local_net = cfg.local_ip & cfg.subnet_mask;
    assign dst_local = (in_dest_ip & cfg.subnet_mask) == local_net;
    assign gw_local  = (in_gateway_ip & cfg.subnet_mask) == local_net;
    assign route_ok  = dst_local || gw_local;
    assign route_ip  = dst_local ? in_dest_ip : in_gateway_ip;
    assign fmt_ok    = (in_hw_space == arpc_pkg::HW_ETHERNET)
                    && (in_hw_len == arpc_pkg::HW_ADDR_LEN)
                    && (in_proto_space == arpc_pkg::PROTO_IPV4)
                    && (in_proto_len == arpc_pkg::PROTO_LEN);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t            state_reg;
    logic              mode_reg;       // 1: received ARP packet
    logic [IP_W-1:0]   key_reg;        // lookup address (next hop / sender)
    logic [MAC_W-1:0]  smac_reg;
    logic              tip_hit_reg;    // ARP packet aimed at local_ip
    logic              reply_ok_reg;   // not a reply and transmitter free
    logic [CW-1:0]     cnt_reg;        // scan read pointer
    logic              cmp_vld_reg;    // RAM data valid for compare
    logic [IW-1:0]     cmp_idx_reg;    // entry whose line is on rdata
    logic              found_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [IW-1:0]     best_rank_reg;
    logic [MAC_W-1:0]  best_mac_reg;
    logic [IW-1:0]     victim_idx_reg; // entry holding rank ENTRIES-1
    logic [ENTRIES-1:0] valid_reg;
    logic [2:0]        res_action_reg;
    logic [IP_W-1:0]   res_hop_reg;
    logic [MAC_W-1:0]  res_mac_reg;
    logic              m_tvalid_reg;
    logic [79:0]       m_tdata_reg;
    logic [2:0]        m_tuser_reg;

    logic in_xfer;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // Line RAM {ip, mac} and recency ranks
    // ---------------------------------------------------------------
    logic              ram_re, ram_we;
    logic [LINE_W-1:0] ram_rdata;
    logic [IW-1:0]     cmp_rank;
    logic              scan_issue;

    // A read is issued for cnt 0..ENTRIES-1; data lands on rdata in the next cycle.
    assign scan_issue = (state_reg == ST_SCAN) && (cnt_reg < CW'(ENTRIES));
    assign ram_re     = scan_issue;

    // Update step: refresh a hit, or learn over the LRU entry.
    logic          learn;
    logic          front_en;
    logic [IW-1:0] front_idx;
    logic [IW-1:0] front_rank;

    assign learn      = mode_reg && !found_reg && tip_hit_reg;
    assign front_en   = (state_reg == ST_UPD) && (found_reg || learn);
    assign front_idx  = found_reg ? best_idx_reg : victim_idx_reg;
    assign front_rank = found_reg ? best_rank_reg : IW'(ENTRIES - 1);
    // mode 0 hits only move the entry; mode 1 rewrites the MAC as well
    assign ram_we     = front_en && mode_reg;

    arpc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (ENTRIES)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (front_idx),
        .wdata ({key_reg, smac_reg}),
        .re    (ram_re),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    arpc_rank #(
        .ENTRIES (ENTRIES)
    ) u_rank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (cmp_idx_reg),
        .rd_rank  (cmp_rank),
        .upd_en   (front_en),
        .upd_idx  (front_idx),
        .upd_rank (front_rank)
    );

    // Match the line on rdata; ties go to the lowest rank.
    logic cmp_hit;
    assign cmp_hit = cmp_vld_reg && valid_reg[cmp_idx_reg]
                  && (ram_rdata[LINE_W-1:MAC_W] == key_reg)
                  && (!found_reg || (cmp_rank < best_rank_reg));

    // ---------------------------------------------------------------
    // Sequencer: IDLE -> SCAN -> UPD -> OUT, or IDLE -> OUT when the
    // item needs no lookup (no route, malformed ARP).
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            // result taken; in ST_OUT the reload below decides instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        mode_reg     <= in_mode;
                        smac_reg     <= in_sender_mac;
                        tip_hit_reg  <= in_mode && (in_target_ip == cfg.local_ip);
                        reply_ok_reg <= (in_arp_opcode != arpc_pkg::OP_REPLY) && !in_tx_busy;
                        key_reg      <= in_mode ? in_sender_ip : route_ip;
                        found_reg    <= 1'b0;
                        cnt_reg      <= '0;
                        cmp_vld_reg  <= 1'b0;
                        res_hop_reg  <= '0;
                        res_mac_reg  <= '0;
                        priority if (!in_mode && !route_ok) begin
                            res_action_reg <= arpc_pkg::ACT_DROP;
                            state_reg      <= ST_OUT;
                        end else if (in_mode && !fmt_ok) begin
                            res_action_reg <= arpc_pkg::ACT_BAD_ARP;
                            state_reg      <= ST_OUT;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    cmp_vld_reg <= scan_issue;
                    cmp_idx_reg <= cnt_reg[IW-1:0];
                    if (scan_issue) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (cmp_hit) begin
                        found_reg     <= 1'b1;
                        best_idx_reg  <= cmp_idx_reg;
                        best_rank_reg <= cmp_rank;
                        best_mac_reg  <= ram_rdata[MAC_W-1:0];
                    end
                    if (cmp_vld_reg && (cmp_rank == IW'(ENTRIES - 1))) begin
                        victim_idx_reg <= cmp_idx_reg;
                    end
                    // last line compared this cycle
                    if (!scan_issue) begin
                        state_reg <= ST_UPD;
                    end
                end

                ST_UPD: begin
                    if (learn) begin
                        valid_reg[front_idx] <= 1'b1;
                    end
                    if (!mode_reg) begin
                        res_hop_reg <= key_reg;
                        if (found_reg) begin
                            res_action_reg <= arpc_pkg::ACT_SEND_MAC;
                            res_mac_reg    <= best_mac_reg;
                        end else begin
                            res_action_reg <= arpc_pkg::ACT_ARP_REQ;
                            res_mac_reg    <= arpc_pkg::MAC_BCAST;
                        end
                    end else if (tip_hit_reg && reply_ok_reg) begin
                        res_action_reg <= arpc_pkg::ACT_REPLY;
                        res_hop_reg    <= key_reg;
                        res_mac_reg    <= smac_reg;
                    end else begin
                        res_action_reg <= arpc_pkg::ACT_NO_REPLY;
                    end
                    state_reg <= ST_OUT;
                end

                ST_OUT: begin
                    // output register free or being drained this cycle
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_mac_reg, res_hop_reg};
                        m_tuser_reg  <= res_action_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_learn_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (front_en && learn) |=> valid_reg[$past(front_idx)])
        else $error("learned entry not marked valid");

    a_valid_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) >= $countones($past(valid_reg))))
        else $error("cache entry lost its valid bit");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result presented outside output state");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we || front_en) |-> (state_reg == ST_UPD) && !ram_re)
        else $error("cache update overlaps the scan");

endmodule

`default_nettype wire
